// File: rtl/asn1_time_to_epoch_defines.svh
// assertion macros shared by the asn1 time converter modules
// expects clk and arst_n in the scope of every use
`ifndef ASN1_TIME_TO_EPOCH_DEFINES_SVH
`define ASN1_TIME_TO_EPOCH_DEFINES_SVH

// same-cycle implication, off during reset
`define ASN1TE_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define ASN1TE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/asn1te_pkg.sv
// types, codes and constants of the asn1 time to epoch converter
// used by asn1te_parse, asn1te_epoch and asn1_time_to_epoch
package asn1te_pkg;

	typedef enum logic [3:0] {
		PH_START  = 4'd0,
		PH_YEAR   = 4'd1,
		PH_MON    = 4'd2,
		PH_DAY    = 4'd3,
		PH_HOUR   = 4'd4,
		PH_MIN    = 4'd5,
		PH_SECOPT = 4'd6,
		PH_SEC    = 4'd7,
		PH_AFTER  = 4'd8,
		PH_ZHP    = 4'd9,
		PH_ZMP    = 4'd10,
		PH_ZHN    = 4'd11,
		PH_ZMN    = 4'd12,
		PH_END    = 4'd13
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FORMAT = 2'd1,
		ST_RANGE  = 2'd2,
		ST_LOCAL  = 2'd3
	} status_t;

	localparam logic [1:0] KIND_UTC = 2'd0;
	localparam logic [1:0] KIND_GEN = 2'd1;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_UPZ   = 8'h5A;

	// floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT for y below 43699
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	localparam logic [13:0] EPOCH_YEAR = 14'd1970;

	// one parsed time string on its way to the epoch arithmetic
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [10:0] zone;     // signed offset in minutes
		status_t     status;
	} fields_t;

	// days of the months before the given one, common year
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] r;
		unique case (month)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/asn1te_parse.sv
// character parser: phase register, digit accumulator and field registers
// depends on asn1te_pkg and asn1_time_to_epoch_defines.svh
`include "asn1_time_to_epoch_defines.svh"

module asn1te_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        ch,
	input  logic [1:0]        kind,
	input  logic              last,
	output asn1te_pkg::fields_t res
);
	import asn1te_pkg::*;

	phase_t      phase_q, phase_n, ph_w, as_ph;
	logic        gen_q, gen_n, gen_w;
	logic [2:0]  cnt_q, cnt_n, cnt_x, need;
	logic [13:0] acc_q, acc_n, acc_x, lo, hi;
	logic [13:0] year_q, year_n;
	logic [3:0]  month_q, month_n;
	logic [4:0]  day_q, day_n;
	logic [4:0]  hour_q, hour_n;
	logic [5:0]  minute_q, minute_n;
	logic [5:0]  second_q, second_n;
	logic [10:0] zone_q, zone_n, zsum;
	logic        err_q, err_n;
	logic        dig, cont, done, use_dig, as_err, as_zclr;
	logic [3:0]  d;

	always_comb begin
		phase_n  = phase_q;
		gen_n    = gen_q;
		cnt_n    = cnt_q;
		acc_n    = acc_q;
		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		zone_n   = zone_q;
		err_n    = err_q;
		ph_w     = phase_q;
		gen_w    = gen_q;
		cont     = 1'b0;
		dig      = (ch >= CH_ZERO) && (ch <= CH_NINE);
		d        = dig ? ch[3:0] : 4'd0;
		acc_x    = 14'(acc_q * 14'd10 + {10'd0, d});
		cnt_x    = cnt_q + 3'd1;
		need     = 3'd2;
		lo       = 14'd0;
		hi       = 14'd59;
		zsum     = 11'(zone_q + {5'd0, acc_x[5:0]});

		if (!err_q) begin
			if (ch == CH_NUL) begin
				err_n = 1'b1;
			end else if (phase_q == PH_START) begin
				priority if (kind == KIND_UTC) begin
					gen_w = 1'b0;
					ph_w  = PH_YEAR;
					cont  = 1'b1;
				end else if (kind == KIND_GEN) begin
					gen_w = 1'b1;
					ph_w  = PH_YEAR;
					cont  = 1'b1;
				end else begin
					err_n = 1'b1;
				end
			end else begin
				cont = 1'b1;
			end
		end

		unique case (ph_w)
			PH_YEAR: begin
				need = gen_w ? 3'd4 : 3'd2;
				hi   = gen_w ? 14'd9999 : 14'd99;
			end
			PH_MON: begin
				lo = 14'd1;
				hi = 14'd12;
			end
			PH_DAY: begin
				lo = 14'd1;
				hi = 14'd31;
			end
			PH_HOUR:         hi = 14'd23;
			PH_ZHP, PH_ZHN:  hi = 14'd12;
			default: ;
		endcase
		done = (cnt_x == need);

		// what follows the seconds or stands in place of them
		as_err  = 1'b0;
		as_zclr = 1'b0;
		priority if (gen_w && (ch == CH_DOT || ch == CH_COMMA || dig)) begin
			as_ph = PH_AFTER;
		end else if (ch == CH_UPZ) begin
			as_ph   = PH_END;
			as_zclr = 1'b1;
		end else if (ch == CH_PLUS) begin
			as_ph = PH_ZHP;
		end else if (ch == CH_MINUS) begin
			as_ph = PH_ZHN;
		end else begin
			as_ph  = PH_AFTER;
			as_err = 1'b1;
		end

		use_dig = cont && dig && (((ph_w >= PH_YEAR) && (ph_w <= PH_SEC)) ||
			((ph_w >= PH_ZHP) && (ph_w <= PH_ZMN)));
		if (use_dig) begin
			cnt_n = done ? 3'd0 : cnt_x;
			acc_n = done ? 14'd0 : acc_x;
			if (done && ((acc_x < lo) || (acc_x > hi))) begin
				err_n = 1'b1;
			end
		end

		if (cont) begin
			if (!dig && (ph_w <= PH_MIN)) begin
				err_n = 1'b1;
			end else begin
				gen_n   = gen_w;
				phase_n = ph_w;
				unique case (ph_w)
					PH_YEAR: begin
						if (done) begin
							if (gen_w) begin
								year_n = acc_x;
							end else if (acc_x < 14'd50) begin
								year_n = 14'(acc_x + 14'd2000);
							end else begin
								year_n = 14'(acc_x + 14'd1900);
							end
							phase_n = PH_MON;
						end
					end
					PH_MON: begin
						if (done) begin
							month_n = acc_x[3:0];
							phase_n = PH_DAY;
						end
					end
					PH_DAY: begin
						if (done) begin
							day_n   = acc_x[4:0];
							phase_n = PH_HOUR;
						end
					end
					PH_HOUR: begin
						if (done) begin
							hour_n  = acc_x[4:0];
							phase_n = PH_MIN;
						end
					end
					PH_MIN: begin
						if (done) begin
							minute_n = acc_x[5:0];
							phase_n  = PH_SECOPT;
						end
					end
					PH_SECOPT: begin
						if (dig) begin
							phase_n = PH_SEC;
						end else begin
							second_n = 6'd0;
							phase_n  = as_ph;
							if (as_zclr) zone_n = 11'd0;
							if (as_err) err_n = 1'b1;
						end
					end
					PH_SEC: begin
						if (!dig) begin
							err_n = 1'b1;
						end else if (done) begin
							second_n = acc_x[5:0];
							phase_n  = PH_AFTER;
						end
					end
					PH_AFTER: begin
						phase_n = as_ph;
						if (as_zclr) zone_n = 11'd0;
						if (as_err) err_n = 1'b1;
					end
					PH_ZHP, PH_ZHN: begin
						if (!dig) begin
							err_n = 1'b1;
						end else if (done) begin
							zone_n  = 11'({4'd0, acc_x[6:0]} * 11'd60);
							phase_n = (ph_w == PH_ZHP) ? PH_ZMP : PH_ZMN;
						end
					end
					PH_ZMP, PH_ZMN: begin
						if (!dig) begin
							err_n = 1'b1;
						end else if (done) begin
							zone_n  = (ph_w == PH_ZMN) ? 11'(-zsum) : zsum;
							phase_n = PH_END;
						end
					end
					default: err_n = 1'b1;
				endcase
			end
		end

		res.year   = year_n;
		res.month  = month_n;
		res.day    = day_n;
		res.hour   = hour_n;
		res.minute = minute_n;
		res.second = second_n;
		res.zone   = zone_n;
		priority if (err_n) begin
			res.status = ST_FORMAT;
		end else if (phase_n == PH_END) begin
			res.status = ST_OK;
		end else if (gen_n && (phase_n == PH_SECOPT || phase_n == PH_AFTER)) begin
			res.status = ST_LOCAL;
		end else begin
			res.status = ST_FORMAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			gen_q    <= 1'b0;
			cnt_q    <= 3'd0;
			acc_q    <= 14'd0;
			year_q   <= 14'd0;
			month_q  <= 4'd0;
			day_q    <= 5'd0;
			hour_q   <= 5'd0;
			minute_q <= 6'd0;
			second_q <= 6'd0;
			zone_q   <= 11'd0;
			err_q    <= 1'b0;
		end else if (fire) begin
			if (last) begin
				// string done, back to the start for the next one
				phase_q  <= PH_START;
				gen_q    <= 1'b0;
				cnt_q    <= 3'd0;
				acc_q    <= 14'd0;
				year_q   <= 14'd0;
				month_q  <= 4'd0;
				day_q    <= 5'd0;
				hour_q   <= 5'd0;
				minute_q <= 6'd0;
				second_q <= 6'd0;
				zone_q   <= 11'd0;
				err_q    <= 1'b0;
			end else begin
				phase_q  <= phase_n;
				gen_q    <= gen_n;
				cnt_q    <= cnt_n;
				acc_q    <= acc_n;
				year_q   <= year_n;
				month_q  <= month_n;
				day_q    <= day_n;
				hour_q   <= hour_n;
				minute_q <= minute_n;
				second_q <= second_n;
				zone_q   <= zone_n;
				err_q    <= err_n;
			end
		end
	end

	`ASN1TE_ASSERT_NEXT(a_clear_after_last, fire && last,
		phase_q == PH_START && !err_q && cnt_q == 3'd0, "parser not cleared after last transaction")
	`ASN1TE_ASSERT_IMPL(a_digit_count, 1'b1, cnt_q <= 3'd3, "digit count past longest field")

endmodule

// File: rtl/asn1te_epoch.sv
// epoch arithmetic pipeline: day count, seconds of day, range check, result register
// depends on asn1te_pkg and asn1_time_to_epoch_defines.svh
`include "asn1_time_to_epoch_defines.svh"

module asn1te_epoch #(
	parameter int TIME_BYTES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  asn1te_pkg::fields_t in_fields,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [38:0]         out_epoch,
	output asn1te_pkg::status_t out_status
);
	import asn1te_pkg::*;

	localparam int WrapBits  = TIME_BYTES * 8;
	localparam int WrapShift = (WrapBits < 40) ? 40 - WrapBits : 0;

	logic rdy2, rdy3, rdy4, rdy5;
	logic valid_s2, valid_s3, valid_s4, valid_s5;

	fields_t f_s2;

	// stage 3
	logic [25:0]        prod;
	logic signed [18:0] sod;
	logic [13:0]        year_s3;
	logic [3:0]         month_s3;
	logic [4:0]         dom_s3;
	logic signed [18:0] sod_s3;
	logic [6:0]         q_s3;
	status_t            status_s3;

	// stage 4
	logic [6:0]         rem, q_dn, q_up, cent_post, cent_pre, cent;
	logic               leap, pre;
	logic [8:0]         yday;
	logic [12:0]        lp;
	logic signed [23:0] ydiff, leap_term, cent_term, days;
	logic signed [23:0] days_s4;
	logic signed [18:0] sod_s4;
	logic               pre_s4, rng_s4;
	status_t            status_s4;

	// output stage
	logic signed [39:0] r, r_w;
	logic               bad;
	logic [38:0]        epoch_s5;
	status_t            status_s5;

	assign rdy5     = !valid_s5 || out_ready;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign in_ready = rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy2) valid_s2 <= in_valid;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && in_valid) f_s2 <= in_fields;
	end

	// year / 100 by reciprocal, seconds within the day
	always_comb begin
		prod = 26'({12'd0, f_s2.year} * {13'd0, DIV100_MUL});
		sod  = signed'({13'd0, f_s2.second})
			+ (signed'({13'd0, f_s2.minute}) - 19'(signed'(f_s2.zone))) * 19'sd60
			+ signed'({14'd0, f_s2.hour}) * 19'sd3600;
	end

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			year_s3   <= f_s2.year;
			month_s3  <= f_s2.month;
			dom_s3    <= f_s2.day - 5'd1;
			sod_s3    <= sod;
			q_s3      <= prod[DIV100_SHIFT +: 7];
			status_s3 <= f_s2.status;
		end
	end

	// leap year, day of year, leap days and century corrections
	always_comb begin
		rem  = 7'(year_s3 - 14'({7'd0, q_s3} * 14'd100));
		leap = ((year_s3[1:0] == 2'd0) && (rem != 7'd0)) ||
			((rem == 7'd0) && (q_s3[1:0] == 2'd0));
		yday = 9'({4'd0, dom_s3} + days_before(month_s3)) +
			9'((leap && (month_s3 > 4'd2)) ? 1 : 0);
		pre  = year_s3 < EPOCH_YEAR;
		// last century strictly below the year, first century at or above it
		q_dn = (rem == 7'd0) ? 7'(q_s3 - 7'd1) : q_s3;
		q_up = (rem == 7'd0) ? q_s3 : 7'(q_s3 + 7'd1);
		cent_post = (q_dn >= 7'd20) ? 7'(q_dn - 7'd20 - ((q_dn >> 2) - 7'd5)) : 7'd0;
		cent_pre  = 7'(7'd15 - q_up + ((q_up + 7'd3) >> 2));
		cent      = (TIME_BYTES > 4) ? (pre ? cent_pre : cent_post) : 7'd0;
		lp = pre ? 13'((11'd1972 - year_s3[10:0]) >> 2) : 13'((year_s3 - 14'd1969) >> 2);
		leap_term = pre ? -signed'({11'd0, lp}) : signed'({11'd0, lp});
		cent_term = pre ? signed'({17'd0, cent}) : -signed'({17'd0, cent});
		ydiff = signed'({10'd0, year_s3}) - 24'sd1970;
		days  = ydiff * 24'sd365 + leap_term + cent_term + signed'({15'd0, yday});
	end

	always_ff @(posedge clk) begin
		if (rdy4 && valid_s3) begin
			days_s4   <= days;
			sod_s4    <= sod_s3;
			pre_s4    <= pre;
			rng_s4    <= (TIME_BYTES == 4) && ((year_s3 < 14'd1900) || (year_s3 > 14'd2040));
			status_s4 <= status_s3;
		end
	end

	// seconds, wrapped to the time width, then the sign check
	always_comb begin
		r   = 40'(days_s4) * 40'sd86400 + 40'(sod_s4);
		r_w = (r <<< WrapShift) >>> WrapShift;
		bad = rng_s4 || (pre_s4 ? !r_w[39] : r_w[39]);
	end

	always_ff @(posedge clk) begin
		if (rdy5 && valid_s4) begin
			if (status_s4 != ST_OK) begin
				epoch_s5  <= 39'd0;
				status_s5 <= status_s4;
			end else if (bad) begin
				epoch_s5  <= 39'd0;
				status_s5 <= ST_RANGE;
			end else begin
				epoch_s5  <= r_w[38:0];
				status_s5 <= ST_OK;
			end
		end
	end

	assign out_valid  = valid_s5;
	assign out_epoch  = epoch_s5;
	assign out_status = status_s5;

	`ASN1TE_ASSERT_IMPL(a_error_zero, valid_s5 && status_s5 != ST_OK, epoch_s5 == 39'd0,
		"nonzero epoch with error status")
	`ASN1TE_ASSERT_NEXT(a_stage_advance, valid_s4 && rdy5, valid_s5,
		"result lost between last stage and output register")

endmodule

// File: rtl/asn1_time_to_epoch.sv
// top level of the asn1 utc/generalized time to unix epoch converter
// depends on asn1te_pkg, asn1te_parse and asn1te_epoch
//
// Takes an ASN.1 UTCTime or GeneralizedTime string one character per
// transaction on the slave stream (tlast on the final character, time kind
// in tuser, sampled on the first character) and returns one transaction per
// string with the Unix epoch seconds and a status (0 ok, 1 format error,
// 2 range error, 3 local time not supported); the seconds are 0 whenever
// the status is not ok. One character is taken every clock cycle, but a
// last character waits while the arithmetic cannot take it; the rate is set
// by the parser's phase and digit registers, which absorb one character per
// cycle. The result leaves through a four-stage arithmetic pipeline that
// ends in a result register. TIME_BYTES sets the width to which the seconds
// wrap and, at 4, limits years to 1900..2040.

module asn1_time_to_epoch #(
	parameter int TIME_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	input  logic [1:0]  s_axis_tuser,   // [1:0] time_kind
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [38:0] epoch_seconds, [39] zero
	output logic [1:0]  m_axis_tuser    // [1:0] status
);
	import asn1te_pkg::*;

	logic       valid_s1, last_s1, fire_s1, ep_ready;
	logic [7:0] char_s1;
	logic [1:0] kind_s1;
	fields_t    res;
	logic [38:0] epoch;
	status_t    status;

	// a last character moves on only when the arithmetic can take it
	assign fire_s1       = valid_s1 && (!last_s1 || ep_ready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			kind_s1 <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	asn1te_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.ch     (char_s1),
		.kind   (kind_s1),
		.last   (last_s1),
		.res    (res)
	);

	asn1te_epoch #(
		.TIME_BYTES (TIME_BYTES)
	) u_epoch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1 && last_s1),
		.in_ready   (ep_ready),
		.in_fields  (res),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_epoch  (epoch),
		.out_status (status)
	);

	assign m_axis_tdata = {1'b0, epoch};
	assign m_axis_tuser = status;

endmodule

// File: sim/tb.sv
// self-checking testbench for asn1_time_to_epoch
// depends on rtl/asn1te_pkg.sv and the rtl of the converter; a scoreboard class
// predicts epoch seconds and status per time string and checks each result

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asn1te_pkg::*;

	localparam int TIME_BYTES = 8;
	localparam logic [1:0] KIND_BAD2 = 2'd2;
	localparam logic [1:0] KIND_BAD3 = 2'd3;
	localparam int RANDOM_CHARS = 850;

	typedef struct packed {
		status_t     status;
		logic [38:0] secs;
	} epoch_result_t;

	// predicts the converter and holds the results still to come
	class epoch_scoreboard #(int BYTES = 8);
		epoch_result_t expected_epochs[$];
		int errors;
		int strings;
		int by_status[4];
		int days_in[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

		phase_t phase;
		bit gen;
		bit bad;
		int unsigned dcount, acc;
		int unsigned year, month, day, hour, minute, second;
		int zone;

		function new();
			clear();
		endfunction

		function void clear();
			phase = PH_START;
			gen = 0;
			bad = 0;
			dcount = 0;
			acc = 0;
			year = 0;
			month = 0;
			day = 0;
			hour = 0;
			minute = 0;
			second = 0;
			zone = 0;
		endfunction

		// one digit into a field of need digits, flags a bad value once complete
		function bit digit_step(int unsigned d, int unsigned need, int unsigned lo,
				int unsigned hi, output int unsigned val);
			acc = acc * 10 + d;
			dcount++;
			if (dcount < need)
				return 0;
			val = acc;
			acc = 0;
			dcount = 0;
			if (val < lo || val > hi)
				bad = 1;
			return 1;
		endfunction

		// character after the seconds, or in place of absent seconds
		function phase_t after_secs(logic [7:0] ch, bit dig);
			if (gen && (ch == CH_DOT || ch == CH_COMMA || dig))
				return PH_AFTER;
			if (ch == CH_UPZ) begin
				zone = 0;
				return PH_END;
			end
			if (ch == CH_PLUS)
				return PH_ZHP;
			if (ch == CH_MINUS)
				return PH_ZHN;
			bad = 1;
			return PH_AFTER;
		endfunction

		function void parse_char(logic [7:0] ch, logic [1:0] kind);
			bit dig;
			int unsigned d, v;
			phase_t ph;
			dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
			d = dig ? ch - CH_ZERO : 0;
			ph = phase;
			if (ch == CH_NUL) begin
				bad = 1;
				return;
			end
			if (ph == PH_START) begin
				if (kind == KIND_UTC)
					gen = 0;
				else if (kind == KIND_GEN)
					gen = 1;
				else begin
					bad = 1;
					return;
				end
				ph = PH_YEAR;
			end
			if (!dig && ph <= PH_MIN) begin
				bad = 1;
				return;
			end
			case (ph)
				PH_YEAR: if (digit_step(d, gen ? 4 : 2, 0, gen ? 9999 : 99, v)) begin
					year = gen ? v : (v < 50 ? 2000 + v : 1900 + v);
					ph = PH_MON;
				end
				PH_MON: if (digit_step(d, 2, 1, 12, v)) begin
					month = v;
					ph = PH_DAY;
				end
				PH_DAY: if (digit_step(d, 2, 1, 31, v)) begin
					day = v;
					ph = PH_HOUR;
				end
				PH_HOUR: if (digit_step(d, 2, 0, 23, v)) begin
					hour = v;
					ph = PH_MIN;
				end
				PH_MIN: if (digit_step(d, 2, 0, 59, v)) begin
					minute = v;
					ph = PH_SECOPT;
				end
				PH_SECOPT: if (dig) begin
					void'(digit_step(d, 2, 0, 59, v));
					ph = PH_SEC;
				end else begin
					second = 0;
					ph = after_secs(ch, dig);
				end
				PH_SEC: if (!dig)
					bad = 1;
				else if (digit_step(d, 2, 0, 59, v)) begin
					second = v;
					ph = PH_AFTER;
				end
				PH_AFTER: ph = after_secs(ch, dig);
				PH_ZHP, PH_ZHN: if (!dig)
					bad = 1;
				else if (digit_step(d, 2, 0, 12, v)) begin
					zone = v * 60;
					ph = (ph == PH_ZHP) ? PH_ZMP : PH_ZMN;
				end
				PH_ZMP, PH_ZMN: if (!dig)
					bad = 1;
				else if (digit_step(d, 2, 0, 59, v)) begin
					zone += v;
					if (ph == PH_ZMN)
						zone = -zone;
					ph = PH_END;
				end
				default: bad = 1;
			endcase
			phase = ph;
		endfunction

		function longint epoch_secs(output bit out_of_range);
			longint y, r, i;
			bit leap;
			int sh;
			out_of_range = 0;
			y = year;
			leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
			r = second;
			r += (longint'(minute) - zone) * 60;
			r += longint'(hour) * 3600;
			r += (longint'(day) - 1) * 86400;
			for (i = longint'(month) - 2; i >= 0 && i < 12; i--)
				r += longint'(days_in[i] + ((i == 1 && leap) ? 1 : 0)) * 86400;
			r += (y - 1970) * 31536000;
			if (BYTES == 4 && (y < 1900 || y > 2040))
				out_of_range = 1;
			if (y < 1970) begin
				r -= ((1970 - y + 2) / 4) * 86400;
				if (BYTES > 4)
					for (i = 1900; i >= y; i -= 100)
						if (i % 400 != 0)
							r += 86400;
			end else begin
				r += ((y - 1970 + 1) / 4) * 86400;
				if (BYTES > 4)
					for (i = 2100; i < y; i += 100)
						if (i % 400 != 0)
							r -= 86400;
			end
			// wrap to the configured width
			if (BYTES < 8) begin
				sh = 64 - BYTES * 8;
				r = (r <<< sh) >>> sh;
			end
			if (y < 1970) begin
				if (r >= 0)
					out_of_range = 1;
			end else if (r < 0)
				out_of_range = 1;
			return r;
		endfunction

		function void add_char(logic [7:0] ch, logic [1:0] kind, bit last);
			epoch_result_t want;
			longint r;
			bit oor;
			if (!bad)
				parse_char(ch, kind);
			if (!last)
				return;
			r = 0;
			if (bad)
				want.status = ST_FORMAT;
			else if (phase == PH_END) begin
				r = epoch_secs(oor);
				want.status = ST_OK;
				if (oor) begin
					want.status = ST_RANGE;
					r = 0;
				end
			end else if (gen && (phase == PH_SECOPT || phase == PH_AFTER))
				want.status = ST_LOCAL;
			else
				want.status = ST_FORMAT;
			want.secs = r[38:0];
			expected_epochs.push_back(want);
			strings++;
			clear();
		endfunction

		function void compare_result(logic [39:0] data, logic [1:0] user);
			epoch_result_t want;
			if (expected_epochs.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result with nothing expected, expected none, actual %h status %0d",
						$time, data, user);
				return;
			end
			want = expected_epochs.pop_front();
			by_status[want.status]++;
			if (data != {1'b0, want.secs}) begin
				errors++;
				if (errors <= 40)
					$display("%0t: epoch seconds expected %0d, actual %0d (tdata %h)",
						$time, $signed(want.secs), $signed(data[38:0]), data);
			end
			if (user != want.status) begin
				errors++;
				if (errors <= 40)
					$display("%0t: status expected %0d, actual %0d", $time, want.status, user);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 0;
	logic [1:0]  s_axis_tuser = 0;
	logic        s_axis_tlast = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	epoch_scoreboard #(TIME_BYTES) sb;

	int burst_left = 0;
	bit steady = 0;
	int chars_sent = 0;
	int rx_cycle = 0;
	int stall_left = 0;

	asn1_time_to_epoch #(.TIME_BYTES(TIME_BYTES)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #4 clk = ~clk;

	// both streams are sampled at the edge, before any update of this step
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.add_char(s_axis_tdata, s_axis_tuser, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				sb.compare_result(m_axis_tdata, m_axis_tuser);
		end
	end

	// receiver: steps through always-ready, random, periodic and stall modes
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 512) % 4)
			0: m_axis_tready <= 1;
			1: m_axis_tready <= $urandom_range(0, 1);
			2: m_axis_tready <= (rx_cycle % 4 == 0);
			default: begin
				if (stall_left != 0) begin
					stall_left <= stall_left - 1;
					m_axis_tready <= 0;
				end else if ($urandom_range(0, 7) == 0) begin
					stall_left <= $urandom_range(1, 12);
					m_axis_tready <= 0;
				end else
					m_axis_tready <= 1;
			end
		endcase
	end

	task automatic send_byte(logic [7:0] ch, logic [1:0] kind, bit last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				s_axis_tvalid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1;
		s_axis_tdata <= ch;
		s_axis_tuser <= kind;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		chars_sent++;
	endtask

	// kind matters on the first character only; later ones carry noise
	task automatic send_bytes(logic [7:0] q[$], logic [1:0] kind);
		steady = ($urandom_range(0, 3) == 0);
		foreach (q[i])
			send_byte(q[i], (i == 0) ? kind : 2'($urandom_range(0, 3)), i == q.size() - 1);
	endtask

	task automatic send_text(string s, logic [1:0] kind);
		logic [7:0] q[$];
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		send_bytes(q, kind);
	endtask

	task automatic put_num(ref logic [7:0] q[$], input int unsigned v, input int n);
		int unsigned scale;
		scale = 1;
		repeat (n - 1) scale *= 10;
		repeat (n) begin
			q.push_back(CH_ZERO + 8'((v / scale) % 10));
			scale /= 10;
		end
	endtask

	// well-formed time string with random fields, sometimes broken afterwards
	task automatic build_time(ref logic [7:0] q[$], output logic [1:0] kind);
		bit gen;
		int pick, pos;
		logic [7:0] extra;
		q.delete();
		gen = $urandom_range(0, 1);
		kind = gen ? KIND_GEN : KIND_UTC;
		if (gen) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				put_num(q, $urandom_range(1900, 2100), 4);
			else if (pick < 8)
				put_num(q, $urandom_range(0, 9999), 4);
			else if (pick == 8)
				put_num(q, $urandom_range(1969, 1970), 4);
			else
				put_num(q, 100 * $urandom_range(0, 99), 4);
		end else
			put_num(q, $urandom_range(0, 99), 2);
		put_num(q, $urandom_range(1, 12), 2);
		put_num(q, $urandom_range(1, 31), 2);
		put_num(q, $urandom_range(0, 23), 2);
		put_num(q, $urandom_range(0, 59), 2);
		if ($urandom_range(0, 4) != 0)
			put_num(q, $urandom_range(0, 59), 2);
		if (gen && $urandom_range(0, 2) == 0) begin
			q.push_back($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
			repeat ($urandom_range(0, 3)) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		pick = $urandom_range(0, 9);
		if (pick < 4)
			q.push_back(CH_UPZ);
		else if (pick < 9) begin
			q.push_back(pick < 7 ? CH_PLUS : CH_MINUS);
			put_num(q, $urandom_range(0, 12), 2);
			put_num(q, $urandom_range(0, 59), 2);
		end
		if ($urandom_range(0, 3) == 0) begin
			pos = $urandom_range(0, q.size() - 1);
			case ($urandom_range(0, 5))
				0: q[pos] = 8'($urandom_range(0, 255));
				1: q[pos] = CH_ZERO + 8'($urandom_range(0, 9));
				2: while (q.size() > pos + 1 && q.size() > 1) void'(q.pop_back());
				3: begin
					case ($urandom_range(0, 5))
						0: extra = CH_UPZ;
						1: extra = CH_ZERO;
						2: extra = CH_PLUS;
						3: extra = CH_MINUS;
						4: extra = CH_DOT;
						default: extra = 8'($urandom_range(0, 255));
					endcase
					q.push_back(extra);
				end
				4: kind = $urandom_range(0, 1) ? KIND_BAD2 : KIND_BAD3;
				default: q[pos] = CH_NUL;
			endcase
		end
	endtask

	initial begin
		logic [7:0] q[$];
		logic [1:0] kind;
		int directed_chars;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// year pivots and extremes
		send_text("491231235959Z", KIND_UTC);
		send_text("500101000000Z", KIND_UTC);
		send_text("7001010000Z", KIND_UTC);
		send_text("19700101000000Z", KIND_GEN);
		send_text("99991231235959Z", KIND_GEN);
		send_text("00000101000000Z", KIND_GEN);
		// fractions and zones
		send_text("20240229120000.123Z", KIND_GEN);
		send_text("20240229120000,5+1259", KIND_GEN);
		send_text("991231235959-0000", KIND_UTC);
		// results that fall on the wrong side of the epoch
		send_text("19700101000000+1259", KIND_GEN);
		send_text("19691231235959-1259", KIND_GEN);
		// century corrections
		send_text("19000301000000Z", KIND_GEN);
		send_text("18000101000000Z", KIND_GEN);
		send_text("21000301000000Z", KIND_GEN);
		send_text("24000301000000-0130", KIND_GEN);
		// missing zone, unknown kind, trailing data
		send_text("20000101000000", KIND_GEN);
		send_text("200001010000", KIND_GEN);
		send_text("000101000000", KIND_UTC);
		send_text("000101000000Z", KIND_BAD2);
		send_text("000101000000Z", KIND_BAD3);
		send_text("000101000000ZZ", KIND_UTC);
		// out of range fields and truncation
		send_text("001301000000Z", KIND_UTC);
		send_text("000100000000Z", KIND_UTC);
		send_text("000101240000Z", KIND_UTC);
		send_text("000101006000Z", KIND_UTC);
		send_text("000101000060Z", KIND_UTC);
		send_text("000101000000+1300", KIND_UTC);
		send_text("000101000000-0060", KIND_UTC);
		send_text("00010100005Z", KIND_UTC);
		send_text("0001", KIND_UTC);
		send_text("0", KIND_GEN);
		// embedded nul and high bytes
		q = '{8'h37, 8'h30, 8'h30, 8'h31, CH_NUL, 8'h31, 8'h30, 8'h30, 8'h30, 8'h30, CH_UPZ};
		send_bytes(q, KIND_UTC);
		q = '{8'hFF, 8'h80};
		send_bytes(q, KIND_GEN);
		directed_chars = chars_sent;

		while (chars_sent - directed_chars < RANDOM_CHARS) begin
			build_time(q, kind);
			send_bytes(q, kind);
		end
		s_axis_tvalid <= 0;

		while (sb.expected_epochs.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d time strings, %0d characters, with directed extremes and random strings",
			sb.strings, chars_sent);
		$display("statuses seen: ok %0d, format %0d, range %0d, local %0d",
			sb.by_status[ST_OK], sb.by_status[ST_FORMAT], sb.by_status[ST_RANGE],
			sb.by_status[ST_LOCAL]);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#5ms;
		$display("timeout waiting for the converter");
		$display("Mismatches found");
		$finish;
	end

endmodule
